// ----- hdl/kvca_pkg.sv -----
// Shared types and constants for the key/value cache append address generator.
package kvca_pkg;

  // Address and field widths
  localparam int unsigned AddrBits   = 48;
  localparam int unsigned MaxHeads   = 32;
  localparam int unsigned HeadBits   = 5;
  localparam int unsigned HeadCntW   = 6;
  localparam int unsigned LayerCntW  = 9;
  localparam int unsigned LayerW     = 8;
  localparam int unsigned SeqW       = 17;
  localparam int unsigned HeadWidthW = 10;
  localparam int unsigned BytesW     = 12;
  localparam int unsigned StrideW    = 29;
  localparam int unsigned LayerOffW  = 43;
  localparam int unsigned CfgIdxW    = 3;

  // Request commands
  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_COMMIT = 1'b1
  } command_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_BAD_LAYER  = 3'd2,
    STAT_NO_PENDING = 3'd3,
    STAT_INCOMPLETE = 3'd4
  } status_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_VALUE  = 2'd2
  } copy_kind_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LAYER_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEAD_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEQ_CAP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEAD_WIDTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KEY_BASE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_VALUE_BASE  = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch an accepted request
    logic check;        // run checks, update token state, compute products
    logic layer_mul;    // layer offset product
    logic base_sum;     // form the key and value row base addresses
    logic load_key;     // load key descriptor into output register
    logic load_value;   // load value descriptor, advance to next head
    logic load_status;  // load status-only result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic copy_go;      // checks passed on an append with nonzero heads
    logic last_head;    // current head is the final one
  } dp_stat_t;

endpackage

// ----- hdl/kvca_ctrl.sv -----
// Controller state machine of the key/value cache append address generator.
module kvca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  kvca_pkg::dp_stat_t dp_stat_i,
  output kvca_pkg::dp_cmd_t  dp_cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_SUM,
    S_KEY,
    S_VALUE,
    S_STATUS
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   emit_state;
  logic   out_load;

  // Output register may take a new result when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_state = (state_q == S_KEY) || (state_q == S_VALUE) || (state_q == S_STATUS);
  assign out_load   = emit_state && out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Commands to the datapath
  always_comb begin
    dp_cmd_o             = '0;
    dp_cmd_o.capture     = (state_q == S_IDLE) && in_valid_i;
    dp_cmd_o.check       = (state_q == S_CHECK);
    dp_cmd_o.layer_mul   = (state_q == S_MUL);
    dp_cmd_o.base_sum    = (state_q == S_SUM);
    dp_cmd_o.load_key    = (state_q == S_KEY) && out_free;
    dp_cmd_o.load_value  = (state_q == S_VALUE) && out_free;
    dp_cmd_o.load_status = (state_q == S_STATUS) && out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_CHECK;
      S_CHECK:  state_d = dp_stat_i.copy_go ? S_MUL : S_STATUS;
      S_MUL:    state_d = S_SUM;
      S_SUM:    state_d = S_KEY;
      S_KEY:    if (out_free) state_d = S_VALUE;
      S_VALUE: begin
        if (out_free) state_d = dp_stat_i.last_head ? S_IDLE : S_KEY;
      end
      S_STATUS: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Output valid follows loads and drains
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/kvca_dp.sv -----
// Datapath: configuration, token state, address arithmetic and output register.
module kvca_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [kvca_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [kvca_pkg::AddrBits-1:0]         cfg_data_i,
  // request fields
  input  logic                                  command_i,
  input  logic [kvca_pkg::LayerW-1:0]           layer_i,
  input  logic [kvca_pkg::AddrBits-1:0]         key_source_addr_i,
  input  logic [kvca_pkg::AddrBits-1:0]         value_source_addr_i,
  // control
  input  kvca_pkg::dp_cmd_t                     dp_cmd_i,
  output kvca_pkg::dp_stat_t                    dp_stat_o,
  // result fields
  output logic [2:0]                            status_o,
  output logic [1:0]                            copy_kind_o,
  output logic [kvca_pkg::HeadBits-1:0]         head_index_o,
  output logic [kvca_pkg::AddrBits-1:0]         dest_addr_o,
  output logic [kvca_pkg::AddrBits-1:0]         src_addr_o,
  output logic [kvca_pkg::BytesW-1:0]           copy_bytes_o,
  output logic [kvca_pkg::SeqW-1:0]             position_o,
  output logic                                  last_o
);

  // Configuration registers
  logic [kvca_pkg::LayerCntW-1:0]  layer_cnt_q;
  logic [kvca_pkg::HeadCntW-1:0]   head_cnt_q;
  logic [kvca_pkg::SeqW-1:0]       seq_cap_q;
  logic [kvca_pkg::HeadWidthW-1:0] head_width_q;
  logic [kvca_pkg::AddrBits-1:0]   key_base_q;
  logic [kvca_pkg::AddrBits-1:0]   value_base_q;

  // Token state
  logic [kvca_pkg::SeqW-1:0]       tokens_q;
  logic [kvca_pkg::LayerCntW-1:0]  pending_q;

  // Request capture
  logic                            cmd_q;
  logic [kvca_pkg::LayerW-1:0]     layer_q;
  logic [kvca_pkg::AddrBits-1:0]   ksrc_q;
  logic [kvca_pkg::AddrBits-1:0]   vsrc_q;
  logic [kvca_pkg::SeqW-1:0]       pos_q;

  // Address setup and per-head walk
  logic [2:0]                      stat_q;
  logic [kvca_pkg::HeadCntW-1:0]   heads_q;
  logic [kvca_pkg::BytesW-1:0]     row_bytes_q;
  logic [kvca_pkg::StrideW-1:0]    stride_q;
  logic [kvca_pkg::StrideW-1:0]    row_off_q;
  logic [13:0]                     lh_q;
  logic [kvca_pkg::LayerOffW-1:0]  layer_off_q;
  logic [kvca_pkg::AddrBits-1:0]   kdst_q;
  logic [kvca_pkg::AddrBits-1:0]   vdst_q;
  logic [kvca_pkg::HeadBits-1:0]   head_q;

  // Output register
  logic [2:0]                      o_stat_q;
  logic [1:0]                      o_kind_q;
  logic [kvca_pkg::HeadBits-1:0]   o_head_q;
  logic [kvca_pkg::AddrBits-1:0]   o_dst_q;
  logic [kvca_pkg::AddrBits-1:0]   o_src_q;
  logic [kvca_pkg::BytesW-1:0]     o_bytes_q;
  logic [kvca_pkg::SeqW-1:0]       o_pos_q;
  logic                            o_last_q;

  logic [kvca_pkg::HeadCntW-1:0]   heads_clamp;
  logic                            is_full;
  logic                            commit_ok;
  logic                            append_ok;
  logic [2:0]                      check_stat;
  logic [26:0]                     seq_hw;
  logic [26:0]                     tok_hw;
  logic                            last_head;

  // Head count above the maximum is taken as the maximum
  assign heads_clamp = (head_cnt_q > kvca_pkg::HeadCntW'(kvca_pkg::MaxHeads))
                       ? kvca_pkg::HeadCntW'(kvca_pkg::MaxHeads) : head_cnt_q;

  // Request checks on captured fields and current state
  assign is_full = (tokens_q >= seq_cap_q);
  always_comb begin
    check_stat = 3'(kvca_pkg::STAT_OK);
    commit_ok  = 1'b0;
    append_ok  = 1'b0;
    if (cmd_q == kvca_pkg::CMD_COMMIT) begin
      if (pending_q == '0) begin
        check_stat = 3'(kvca_pkg::STAT_NO_PENDING);
      end else if (pending_q != layer_cnt_q) begin
        check_stat = 3'(kvca_pkg::STAT_INCOMPLETE);
      end else if (is_full) begin
        check_stat = 3'(kvca_pkg::STAT_FULL);
      end else begin
        commit_ok = 1'b1;
      end
    end else begin
      if (is_full) begin
        check_stat = 3'(kvca_pkg::STAT_FULL);
      end else if (({1'b0, layer_q} >= layer_cnt_q) || ({1'b0, layer_q} != pending_q)) begin
        check_stat = 3'(kvca_pkg::STAT_BAD_LAYER);
      end else begin
        append_ok = 1'b1;
      end
    end
  end

  // Products for the row stride and the token row offset
  assign seq_hw = 27'(seq_cap_q) * 27'(head_width_q);
  assign tok_hw = 27'(tokens_q) * 27'(head_width_q);

  assign last_head = ({1'b0, head_q} + kvca_pkg::HeadCntW'(1)) == heads_q;

  assign dp_stat_o.copy_go   = append_ok && (heads_clamp != '0);
  assign dp_stat_o.last_head = last_head;

  // Configuration registers and token state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_cnt_q  <= kvca_pkg::LayerCntW'(1);
      head_cnt_q   <= kvca_pkg::HeadCntW'(1);
      seq_cap_q    <= kvca_pkg::SeqW'(1);
      head_width_q <= kvca_pkg::HeadWidthW'(1);
      key_base_q   <= '0;
      value_base_q <= '0;
      tokens_q     <= '0;
      pending_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          kvca_pkg::CFG_LAYER_COUNT: layer_cnt_q  <= cfg_data_i[kvca_pkg::LayerCntW-1:0];
          kvca_pkg::CFG_HEAD_COUNT:  head_cnt_q   <= cfg_data_i[kvca_pkg::HeadCntW-1:0];
          kvca_pkg::CFG_SEQ_CAP:     seq_cap_q    <= cfg_data_i[kvca_pkg::SeqW-1:0];
          kvca_pkg::CFG_HEAD_WIDTH:  head_width_q <= cfg_data_i[kvca_pkg::HeadWidthW-1:0];
          kvca_pkg::CFG_KEY_BASE:    key_base_q   <= cfg_data_i;
          kvca_pkg::CFG_VALUE_BASE:  value_base_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (dp_cmd_i.check) begin
        if (commit_ok) begin
          pending_q <= '0;
          tokens_q  <= tokens_q + kvca_pkg::SeqW'(1);
        end else if (append_ok) begin
          pending_q <= pending_q + kvca_pkg::LayerCntW'(1);
        end
      end
    end
  end

  // Request capture, address setup and per-head walk
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q   <= command_i;
      layer_q <= layer_i;
      ksrc_q  <= key_source_addr_i;
      vsrc_q  <= value_source_addr_i;
      pos_q   <= tokens_q;
    end
    if (dp_cmd_i.check) begin
      stat_q      <= check_stat;
      heads_q     <= heads_clamp;
      row_bytes_q <= {head_width_q, 2'b00};
      stride_q    <= {seq_hw, 2'b00};
      row_off_q   <= {tok_hw, 2'b00};
      lh_q        <= 14'(layer_q) * 14'(heads_clamp);
      head_q      <= '0;
    end
    if (dp_cmd_i.layer_mul) begin
      layer_off_q <= kvca_pkg::LayerOffW'(lh_q) * kvca_pkg::LayerOffW'(stride_q);
    end
    if (dp_cmd_i.base_sum) begin
      kdst_q <= key_base_q + kvca_pkg::AddrBits'(layer_off_q)
                + kvca_pkg::AddrBits'(row_off_q);
      vdst_q <= value_base_q + kvca_pkg::AddrBits'(layer_off_q)
                + kvca_pkg::AddrBits'(row_off_q);
    end
    // step to the next head after its value descriptor
    if (dp_cmd_i.load_value) begin
      kdst_q <= kdst_q + kvca_pkg::AddrBits'(stride_q);
      vdst_q <= vdst_q + kvca_pkg::AddrBits'(stride_q);
      ksrc_q <= ksrc_q + kvca_pkg::AddrBits'(row_bytes_q);
      vsrc_q <= vsrc_q + kvca_pkg::AddrBits'(row_bytes_q);
      head_q <= head_q + kvca_pkg::HeadBits'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_key) begin
      o_stat_q  <= 3'(kvca_pkg::STAT_OK);
      o_kind_q  <= 2'(kvca_pkg::KIND_KEY);
      o_head_q  <= head_q;
      o_dst_q   <= kdst_q;
      o_src_q   <= ksrc_q;
      o_bytes_q <= row_bytes_q;
      o_pos_q   <= pos_q;
      o_last_q  <= 1'b0;
    end else if (dp_cmd_i.load_value) begin
      o_stat_q  <= 3'(kvca_pkg::STAT_OK);
      o_kind_q  <= 2'(kvca_pkg::KIND_VALUE);
      o_head_q  <= head_q;
      o_dst_q   <= vdst_q;
      o_src_q   <= vsrc_q;
      o_bytes_q <= row_bytes_q;
      o_pos_q   <= pos_q;
      o_last_q  <= last_head;
    end else if (dp_cmd_i.load_status) begin
      o_stat_q  <= stat_q;
      o_kind_q  <= 2'(kvca_pkg::KIND_STATUS);
      o_head_q  <= '0;
      o_dst_q   <= '0;
      o_src_q   <= '0;
      o_bytes_q <= '0;
      o_pos_q   <= pos_q;
      o_last_q  <= 1'b1;
    end
  end

  assign status_o     = o_stat_q;
  assign copy_kind_o  = o_kind_q;
  assign head_index_o = o_head_q;
  assign dest_addr_o  = o_dst_q;
  assign src_addr_o   = o_src_q;
  assign copy_bytes_o = o_bytes_q;
  assign position_o   = o_pos_q;
  assign last_o       = o_last_q;

endmodule

// ----- hdl/kv_cache_append_address_generator_top.sv -----
// Top level of the key/value cache append address generator.
//
// Requests enter on the in_* channel (valid/stall): an append names one layer
// and gives packed key and value source rows; a commit closes the open token.
// Results leave on the out_* channel (valid/stall), one transaction each; last_o
// marks the final result of a request. Configuration registers are written over
// the cfg_* channel (valid/ready, always ready); the user must write them only
// while the block is idle; the block does not enforce this. A request is taken
// only in the idle state; in_stall_o is high while one is being worked on.
// Rejected requests, commits and zero-head appends give one status-only result.
// A passing append with H heads goes through capture, the checks with the
// stride and row products, the layer offset multiply and the base address sum,
// then gives 2*H descriptors, one per cycle unless the output is stalled.
// Descriptor generation is bound by the single output register.
// A stalled receiver holds the output register and the generator waits on it;
// the next request may be accepted while the final result still waits.
// Reset clears the token count and pending layers, returns the registers to
// their defaults (one layer, one head, capacity one, width one, zero bases)
// and empties the output register.
module kv_cache_append_address_generator_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [kvca_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [kvca_pkg::AddrBits-1:0]         cfg_data_i,
  // requests
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  command_i,
  input  logic [kvca_pkg::LayerW-1:0]           layer_i,
  input  logic [kvca_pkg::AddrBits-1:0]         key_source_addr_i,
  input  logic [kvca_pkg::AddrBits-1:0]         value_source_addr_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [2:0]                            status_o,
  output logic [1:0]                            copy_kind_o,
  output logic [kvca_pkg::HeadBits-1:0]         head_index_o,
  output logic [kvca_pkg::AddrBits-1:0]         dest_addr_o,
  output logic [kvca_pkg::AddrBits-1:0]         src_addr_o,
  output logic [kvca_pkg::BytesW-1:0]           copy_bytes_o,
  output logic [kvca_pkg::SeqW-1:0]             position_o,
  output logic                                  last_o
);

  kvca_pkg::dp_cmd_t  dp_cmd;
  kvca_pkg::dp_stat_t dp_stat;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  kvca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_stat_i   (dp_stat),
    .dp_cmd_o    (dp_cmd)
  );

  kvca_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .command_i           (command_i),
    .layer_i             (layer_i),
    .key_source_addr_i   (key_source_addr_i),
    .value_source_addr_i (value_source_addr_i),
    .dp_cmd_i            (dp_cmd),
    .dp_stat_o           (dp_stat),
    .status_o            (status_o),
    .copy_kind_o         (copy_kind_o),
    .head_index_o        (head_index_o),
    .dest_addr_o         (dest_addr_o),
    .src_addr_o          (src_addr_o),
    .copy_bytes_o        (copy_bytes_o),
    .position_o          (position_o),
    .last_o              (last_o)
  );

endmodule

// ----- tb/tb_kv_cache_append_address_generator_top.sv -----
// Self-checking testbench for the key/value cache append address generator.
module tb_kv_cache_append_address_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 80;
  localparam int RequestTarget = 480;

  // Register indexes the block does not decode
  localparam logic [kvca_pkg::CfgIdxW-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [kvca_pkg::CfgIdxW-1:0] CFG_UNUSED_HI = 3'd7;

  // One result transaction as seen on the output channel
  typedef struct {
    kvca_pkg::status_e                status;
    kvca_pkg::copy_kind_e             kind;
    logic [kvca_pkg::HeadBits-1:0]    head;
    logic [kvca_pkg::AddrBits-1:0]    dest;
    logic [kvca_pkg::AddrBits-1:0]    src;
    logic [kvca_pkg::BytesW-1:0]      bytes;
    logic [kvca_pkg::SeqW-1:0]        position;
    logic                             last;
  } descriptor_t;

  // Cache layout tracker: predicts copy descriptors and checks them in order
  class kv_append_scoreboard;
    logic [kvca_pkg::LayerCntW-1:0]  layer_total;
    logic [kvca_pkg::HeadCntW-1:0]   num_heads;
    logic [kvca_pkg::SeqW-1:0]       capacity;
    logic [kvca_pkg::HeadWidthW-1:0] row_elems;
    logic [kvca_pkg::AddrBits-1:0]   key_base;
    logic [kvca_pkg::AddrBits-1:0]   value_base;
    logic [kvca_pkg::SeqW-1:0]       token_count;
    logic [kvca_pkg::LayerCntW-1:0]  layers_open;
    descriptor_t                     expected_descriptors[$];
    int                              errors;

    function new();
      layer_total = kvca_pkg::LayerCntW'(1);
      num_heads   = kvca_pkg::HeadCntW'(1);
      capacity    = kvca_pkg::SeqW'(1);
      row_elems   = kvca_pkg::HeadWidthW'(1);
      key_base    = '0;
      value_base  = '0;
      token_count = '0;
      layers_open = '0;
      errors      = 0;
    endfunction

    function void write_register(logic [kvca_pkg::CfgIdxW-1:0] idx,
                                 logic [kvca_pkg::AddrBits-1:0] data);
      case (idx)
        kvca_pkg::CFG_LAYER_COUNT: layer_total = data[kvca_pkg::LayerCntW-1:0];
        kvca_pkg::CFG_HEAD_COUNT:  num_heads   = data[kvca_pkg::HeadCntW-1:0];
        kvca_pkg::CFG_SEQ_CAP:     capacity    = data[kvca_pkg::SeqW-1:0];
        kvca_pkg::CFG_HEAD_WIDTH:  row_elems   = data[kvca_pkg::HeadWidthW-1:0];
        kvca_pkg::CFG_KEY_BASE:    key_base    = data;
        kvca_pkg::CFG_VALUE_BASE:  value_base  = data;
        default: ;
      endcase
    endfunction

    // Status-only result, position taken before any state update
    function void push_status(kvca_pkg::status_e st);
      descriptor_t d;
      d = '{status: st, kind: kvca_pkg::KIND_STATUS, head: '0, dest: '0, src: '0,
            bytes: '0, position: token_count, last: 1'b1};
      expected_descriptors.push_back(d);
    endfunction

    function void note_request(kvca_pkg::command_e cmd, logic [kvca_pkg::LayerW-1:0] layer,
                               logic [kvca_pkg::AddrBits-1:0] ksrc,
                               logic [kvca_pkg::AddrBits-1:0] vsrc);
      logic [63:0] heads, row_bytes, stride, layer_off, row_off, kbase, vbase;
      descriptor_t d;
      int h;
      // commit: nothing open, token incomplete, cache full, then close token
      if (cmd == kvca_pkg::CMD_COMMIT) begin
        if (layers_open == 0) push_status(kvca_pkg::STAT_NO_PENDING);
        else if (layers_open != layer_total) push_status(kvca_pkg::STAT_INCOMPLETE);
        else if (token_count >= capacity) push_status(kvca_pkg::STAT_FULL);
        else begin
          push_status(kvca_pkg::STAT_OK);
          layers_open = '0;
          token_count = token_count + 1'b1;
        end
        return;
      end
      // append checks in priority order
      if (token_count >= capacity) begin
        push_status(kvca_pkg::STAT_FULL);
        return;
      end
      if (layer >= layer_total || layer != layers_open) begin
        push_status(kvca_pkg::STAT_BAD_LAYER);
        return;
      end
      heads     = (num_heads > kvca_pkg::MaxHeads) ? 64'(kvca_pkg::MaxHeads)
                                                   : 64'(num_heads);
      row_bytes = 64'(row_elems) * 4;
      stride    = 64'(capacity) * row_bytes;
      layer_off = 64'(layer) * heads * stride;
      row_off   = 64'(token_count) * row_bytes;
      kbase     = 64'(key_base) + layer_off + row_off;
      vbase     = 64'(value_base) + layer_off + row_off;
      layers_open = layers_open + 1'b1;
      if (heads == 0) begin
        push_status(kvca_pkg::STAT_OK);
        return;
      end
      // key then value row per head, addresses wrap at the address width
      for (h = 0; h < heads; h++) begin
        d.status   = kvca_pkg::STAT_OK;
        d.kind     = kvca_pkg::KIND_KEY;
        d.head     = kvca_pkg::HeadBits'(h);
        d.dest     = kvca_pkg::AddrBits'(kbase + 64'(h) * stride);
        d.src      = kvca_pkg::AddrBits'(64'(ksrc) + 64'(h) * row_bytes);
        d.bytes    = kvca_pkg::BytesW'(row_bytes);
        d.position = token_count;
        d.last     = 1'b0;
        expected_descriptors.push_back(d);
        d.kind = kvca_pkg::KIND_VALUE;
        d.dest = kvca_pkg::AddrBits'(vbase + 64'(h) * stride);
        d.src  = kvca_pkg::AddrBits'(64'(vsrc) + 64'(h) * row_bytes);
        d.last = (64'(h) == heads - 1);
        expected_descriptors.push_back(d);
      end
    endfunction

    function void compare_field(string name, logic [kvca_pkg::AddrBits-1:0] want,
                                logic [kvca_pkg::AddrBits-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_descriptor(descriptor_t got);
      descriptor_t want;
      if (expected_descriptors.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d kind %0d head %0d", $time,
                 got.status, got.kind, got.head);
        return;
      end
      want = expected_descriptors.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("copy_kind", want.kind, got.kind);
      compare_field("head_index", want.head, got.head);
      compare_field("dest_addr", want.dest, got.dest);
      compare_field("src_addr", want.src, got.src);
      compare_field("copy_bytes", want.bytes, got.bytes);
      compare_field("position", want.position, got.position);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [kvca_pkg::CfgIdxW-1:0]      cfg_index_i = '0;
  logic [kvca_pkg::AddrBits-1:0]     cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              command_i = 1'b0;
  logic [kvca_pkg::LayerW-1:0]       layer_i = '0;
  logic [kvca_pkg::AddrBits-1:0]     key_source_addr_i = '0;
  logic [kvca_pkg::AddrBits-1:0]     value_source_addr_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [2:0]                        status_o;
  logic [1:0]                        copy_kind_o;
  logic [kvca_pkg::HeadBits-1:0]     head_index_o;
  logic [kvca_pkg::AddrBits-1:0]     dest_addr_o;
  logic [kvca_pkg::AddrBits-1:0]     src_addr_o;
  logic [kvca_pkg::BytesW-1:0]       copy_bytes_o;
  logic [kvca_pkg::SeqW-1:0]         position_o;
  logic                              last_o;

  kv_append_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int requests_sent  = 0;
  int idle_cycles    = 0;

  kv_cache_append_address_generator_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor and receiver stall generation
  always @(posedge clk_i) begin
    descriptor_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status   = kvca_pkg::status_e'(status_o);
      got.kind     = kvca_pkg::copy_kind_e'(copy_kind_o);
      got.head     = head_index_o;
      got.dest     = dest_addr_o;
      got.src      = src_addr_o;
      got.bytes    = copy_bytes_o;
      got.position = position_o;
      got.last     = last_o;
      sb.check_descriptor(got);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: ends the run after too long without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time,
               sb.expected_descriptors.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [kvca_pkg::AddrBits-1:0] rand_addr();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return kvca_pkg::AddrBits'({$urandom, $urandom});
  endfunction

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_request(kvca_pkg::command_e cmd, logic [kvca_pkg::LayerW-1:0] layer,
                              logic [kvca_pkg::AddrBits-1:0] ksrc,
                              logic [kvca_pkg::AddrBits-1:0] vsrc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    command_i           <= cmd;
    layer_i             <= layer;
    key_source_addr_i   <= ksrc;
    value_source_addr_i <= vsrc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(cmd, layer, ksrc, vsrc);
    requests_sent++;
  endtask

  // Stop sending and wait for every predicted result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_descriptors.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_register(logic [kvca_pkg::CfgIdxW-1:0] idx,
                                  logic [kvca_pkg::AddrBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_register(idx, data);
  endtask

  // Reprogram all registers once the block is idle
  task automatic set_layout(logic [kvca_pkg::LayerCntW-1:0] lc,
                            logic [kvca_pkg::HeadCntW-1:0] hc,
                            logic [kvca_pkg::SeqW-1:0] cap,
                            logic [kvca_pkg::HeadWidthW-1:0] hw,
                            logic [kvca_pkg::AddrBits-1:0] kb,
                            logic [kvca_pkg::AddrBits-1:0] vb);
    drain();
    program_register(kvca_pkg::CFG_LAYER_COUNT, kvca_pkg::AddrBits'(lc));
    program_register(kvca_pkg::CFG_HEAD_COUNT, kvca_pkg::AddrBits'(hc));
    program_register(kvca_pkg::CFG_SEQ_CAP, kvca_pkg::AddrBits'(cap));
    program_register(kvca_pkg::CFG_HEAD_WIDTH, kvca_pkg::AddrBits'(hw));
    program_register(kvca_pkg::CFG_KEY_BASE, kb);
    program_register(kvca_pkg::CFG_VALUE_BASE, vb);
    if ($urandom_range(2) == 0)
      program_register($urandom_range(1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, rand_addr());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_layout();
    logic [kvca_pkg::LayerCntW-1:0]  lc;
    logic [kvca_pkg::HeadCntW-1:0]   hc;
    logic [kvca_pkg::SeqW-1:0]       cap;
    logic [kvca_pkg::HeadWidthW-1:0] hw;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) lc = kvca_pkg::LayerCntW'($urandom_range(4, 1));
    else if (pick < 70) lc = '0;
    else if (pick < 80) lc = kvca_pkg::LayerCntW'($urandom_range(16, 5));
    else if (pick < 90) lc = kvca_pkg::LayerCntW'(256);
    else lc = kvca_pkg::LayerCntW'($urandom_range(511));
    // mostly keep an open token completable
    if (sb.layers_open > lc && $urandom_range(4) != 0)
      lc = kvca_pkg::LayerCntW'(sb.layers_open + $urandom_range(2));
    pick = $urandom_range(99);
    if (pick < 55) hc = kvca_pkg::HeadCntW'($urandom_range(4, 1));
    else if (pick < 65) hc = '0;
    else if (pick < 75) hc = kvca_pkg::HeadCntW'(kvca_pkg::MaxHeads);
    else if (pick < 85) hc = kvca_pkg::HeadCntW'($urandom_range(63, 33));
    else hc = kvca_pkg::HeadCntW'($urandom_range(31, 5));
    pick = $urandom_range(99);
    if (pick < 50) cap = kvca_pkg::SeqW'(sb.token_count + $urandom_range(6, 1));
    else if (pick < 65) cap = sb.token_count;
    else if (pick < 85) cap = kvca_pkg::SeqW'($urandom_range(17'h1FFFF));
    else cap = $urandom_range(1) ? 17'h1FFFF : 17'h0;
    pick = $urandom_range(9);
    if (pick == 0) hw = '0;
    else if (pick == 1) hw = 10'h3FF;
    else hw = kvca_pkg::HeadWidthW'($urandom_range(10'h3FF));
    set_layout(lc, hc, cap, hw, rand_addr(), rand_addr());
  endtask

  // Mostly the next step of a well-formed token, the rest broken or noise
  task automatic send_random_request();
    logic [kvca_pkg::LayerW-1:0] layer;
    kvca_pkg::command_e cmd;
    int pick;
    pick  = $urandom_range(99);
    cmd   = kvca_pkg::CMD_APPEND;
    layer = kvca_pkg::LayerW'($urandom_range(255));
    if (pick < 70) begin
      if (sb.layers_open >= sb.layer_total || sb.layers_open > 255) cmd = kvca_pkg::CMD_COMMIT;
      else layer = sb.layers_open[kvca_pkg::LayerW-1:0];
    end else if (pick < 80) begin
      cmd = kvca_pkg::CMD_COMMIT;
    end else if (pick < 90) begin
      case ($urandom_range(3))
        0: layer = kvca_pkg::LayerW'(sb.layers_open + 1);
        1: layer = kvca_pkg::LayerW'(sb.layers_open - 1);
        2: layer = kvca_pkg::LayerW'(sb.layer_total);
        default: layer = kvca_pkg::LayerW'(sb.layer_total - 1);
      endcase
    end else begin
      cmd = kvca_pkg::command_e'($urandom_range(1));
    end
    send_request(cmd, layer, rand_addr(), rand_addr());
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: order checks, wrap of addresses, full cache
    set_idle(0, 0);
    set_layout(9'd2, 6'd2, 17'd3, 10'h3FF, '1, 48'h8000_0000_0000);
    send_request(kvca_pkg::CMD_COMMIT, 8'd0, rand_addr(), rand_addr());   // nothing pending
    send_request(kvca_pkg::CMD_APPEND, 8'd1, rand_addr(), rand_addr());   // missing layer
    send_request(kvca_pkg::CMD_APPEND, 8'd2, rand_addr(), rand_addr());   // layer out of range
    send_request(kvca_pkg::CMD_APPEND, 8'd255, '1, '0);
    send_request(kvca_pkg::CMD_APPEND, 8'd0, '1, '1);                     // addresses wrap
    send_request(kvca_pkg::CMD_COMMIT, 8'd0, '0, '0);                     // incomplete token
    send_request(kvca_pkg::CMD_APPEND, 8'd0, rand_addr(), rand_addr());   // repeated layer
    send_request(kvca_pkg::CMD_APPEND, 8'd1, rand_addr(), rand_addr());
    send_request(kvca_pkg::CMD_COMMIT, 8'd255, '1, '1);
    repeat (2) begin
      send_request(kvca_pkg::CMD_APPEND, 8'd0, rand_addr(), rand_addr());
      send_request(kvca_pkg::CMD_APPEND, 8'd1, rand_addr(), rand_addr());
      send_request(kvca_pkg::CMD_COMMIT, 8'd0, rand_addr(), rand_addr());
    end
    send_request(kvca_pkg::CMD_APPEND, 8'd0, rand_addr(), rand_addr());   // cache full
    send_request(kvca_pkg::CMD_COMMIT, 8'd0, rand_addr(), rand_addr());

    // Directed: head clamp, zero width, commit into a shrunk cache, zero heads/layers
    set_idle(27, 27);
    set_layout(9'd1, 6'd33, 17'h1FFFF, 10'd0, rand_addr(), rand_addr());
    send_request(kvca_pkg::CMD_APPEND, 8'd0, rand_addr(), rand_addr());
    send_request(kvca_pkg::CMD_COMMIT, 8'd0, rand_addr(), rand_addr());
    send_request(kvca_pkg::CMD_APPEND, 8'd0, rand_addr(), rand_addr());
    set_layout(9'd1, 6'd63, sb.token_count, 10'd512, '1, '1);
    send_request(kvca_pkg::CMD_COMMIT, 8'd0, rand_addr(), rand_addr());
    send_request(kvca_pkg::CMD_APPEND, 8'd0, rand_addr(), rand_addr());
    set_layout(9'd1, 6'd0, 17'h1FFFF, 10'h3FF, '0, '0);
    send_request(kvca_pkg::CMD_COMMIT, 8'd0, rand_addr(), rand_addr());
    send_request(kvca_pkg::CMD_APPEND, 8'd0, rand_addr(), rand_addr());
    set_layout(9'd0, 6'd1, 17'h1FFFF, 10'd1, rand_addr(), rand_addr());
    send_request(kvca_pkg::CMD_APPEND, 8'd0, rand_addr(), rand_addr());
    send_request(kvca_pkg::CMD_COMMIT, 8'd0, rand_addr(), rand_addr());

    // Random phases cycling through the idle patterns
    phase = 0;
    while (requests_sent < RequestTarget) begin
      case (phase % 4)
        0: set_idle(0, 0);
        1: set_idle(79, 0);
        2: set_idle(0, 79);
        default: set_idle(27, 27);
      endcase
      random_layout();
      repeat ($urandom_range(40, 20)) send_random_request();
      phase++;
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
